// ----- sv/fhh_pkg.sv -----
// Shared types, codes and defaults for the frame history 2D histogram.
// Used by frame_history_2d_histogram; depends on nothing.
package fhh_pkg;

    // Default sizes of the histogram store
    localparam int FRAME_SLOTS_DEF = 4;
    localparam int MAX_WIDTH_DEF   = 128;
    localparam int MAX_HEIGHT_DEF  = 128;
    localparam int COUNT_BITS_DEF  = 32;

    // Fixed field widths
    localparam int FRAME_W   = 16;
    localparam int COORD_W   = 7;
    localparam int WEIGHT_W  = 16;
    localparam int RESULT_W  = 32;
    localparam int GRID_W    = 8;
    localparam int MODE_W    = 2;
    localparam int CHAN_W    = 8;
    localparam int QUOT_W    = 8;

    // Configuration port
    localparam int PADDR_W   = 4;
    localparam int PDATA_W   = 32;

    // Reciprocal shift used to reduce the frame number to a slot
    localparam int RECIP_K   = 20;

    // Colour constants
    localparam logic [CHAN_W-1:0] CHAN_BASE  = 8'd100;
    localparam int                RED_SPAN   = 155;
    localparam int                GRAY_SPAN  = 255;

    // Register indexes
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_COLOUR_MODE = 2'd2;

    // Register reset values
    localparam logic [GRID_W-1:0] GRID_WIDTH_RST  = 8'd128;
    localparam logic [GRID_W-1:0] GRID_HEIGHT_RST = 8'd128;

    // Action codes
    localparam logic [1:0] ACT_START_FRAME = 2'd0;
    localparam logic [1:0] ACT_ADD_POINT   = 2'd1;
    localparam logic [1:0] ACT_ADD_WEIGHT  = 2'd2;
    localparam logic [1:0] ACT_READ_BIN    = 2'd3;

    // Colour modes
    localparam logic [MODE_W-1:0] MODE_RED  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_GRAY = 2'd1;

    typedef struct packed {
        logic [1:0]          action;
        logic [FRAME_W-1:0]  frame;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [WEIGHT_W-1:0] weight;
    } in_item_t;

    typedef struct packed {
        logic [RESULT_W-1:0] count;
        logic [RESULT_W-1:0] peak;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                lit;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SLOT,
        ST_MOD,
        ST_ISSUE,
        ST_COPY,
        ST_COPY_LAST,
        ST_MODIFY,
        ST_FETCH,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// ----- sv/fhh_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Depends on nothing.
module fhh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/frame_history_2d_histogram.sv -----
// Top level of the frame history 2D histogram: control, arithmetic and
// configuration registers. Depends on fhh_pkg and fhh_ram.
//
//  Channel  Direction  Handshake            Payload
//  s_       in         s_valid / s_ready    in_item_t  (action, frame, x, y, weight)
//  m_       out        m_valid / m_ready    out_item_t (count, peak, red, green, blue, lit)
//  APB      in         psel/penable/pready  grid_width, grid_height, colour_mode
//
// One item at a time: s_ready is high only in ST_IDLE. An in-grid add passes ST_SLOT,
// ST_MOD, ST_ISSUE and ST_MODIFY, an in-grid read ST_FETCH in place of ST_MODIFY,
// and a lit read then the 8-step restoring divider. Start frame copies the previous
// slot, one bin per cycle through the single RAM read port. After reset the store
// is cleared, one entry a cycle, FRAME_SLOTS*SLOT_BINS entries (65536 by default)
// with s_ready low. A result waits in the output register while the next item is
// accepted and worked on; a finished item holds until that register drains.
module frame_history_2d_histogram
    import fhh_pkg::*;
#(
    parameter int FRAME_SLOTS = FRAME_SLOTS_DEF,
    parameter int MAX_WIDTH   = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT  = MAX_HEIGHT_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // input items
    input  logic               s_valid,
    output logic               s_ready,
    input  in_item_t           s_data,
    // result items
    output logic               m_valid,
    input  logic               m_ready,
    output out_item_t          m_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int SLOT_BINS   = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_DEPTH = FRAME_SLOTS * SLOT_BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int BIN_W       = (SLOT_BINS > 1) ? $clog2(SLOT_BINS) : 1;
    localparam int SLOT_W      = $clog2(FRAME_SLOTS);
    localparam int RECIP       = (1 << RECIP_K) / FRAME_SLOTS;
    localparam int PROD_W      = FRAME_W + RECIP_K;
    localparam int SUM_W       = ((COUNT_BITS > WEIGHT_W) ? COUNT_BITS : WEIGHT_W) + 1;
    localparam int NUM_W       = COUNT_BITS + QUOT_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [SLOT_W-1:0]     prev_reg, prev_next;
    logic                  in_grid_reg, in_grid_next;
    logic [BIN_W-1:0]      off_reg, off_next;
    logic [ADDR_W-1:0]     addr_reg, addr_next;
    logic [ADDR_W-1:0]     src_base_reg, src_base_next;
    logic [ADDR_W-1:0]     dst_base_reg, dst_base_next;
    logic [BIN_W-1:0]      idx_reg, idx_next;
    logic [BIN_W-1:0]      widx_reg, widx_next;
    logic                  act_reg, act_next;
    logic [ADDR_W-1:0]     clr_reg, clr_next;
    logic [COUNT_BITS-1:0] peak_reg, peak_next;
    logic [COUNT_BITS-1:0] c_reg, c_next;
    logic [NUM_W-1:0]      rem_reg, rem_next;
    logic [NUM_W-1:0]      dsr_reg, dsr_next;
    logic [QUOT_W-1:0]     q_reg, q_next;
    logic [2:0]            step_reg, step_next;
    out_item_t             res_reg, res_next;
    out_item_t             out_reg, out_next;
    logic                  m_valid_reg, m_valid_next;
    logic [GRID_W-1:0]     grid_width_reg, grid_width_next;
    logic [GRID_W-1:0]     grid_height_reg, grid_height_next;
    logic [MODE_W-1:0]     colour_mode_reg, colour_mode_next;

    // RAM port
    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]     ram_raddr;
    logic [COUNT_BITS-1:0] ram_rdata;

    // Datapath helpers
    logic [FRAME_W-1:0]    q_est;
    logic [FRAME_W-1:0]    q_mul;
    logic [FRAME_W-1:0]    frame_rem;
    logic [FRAME_W-1:0]    frame_fix;
    logic [SUM_W-1:0]      add_amt;
    logic [SUM_W-1:0]      sum;
    logic [COUNT_BITS-1:0] sat;
    logic                  div_ge;
    logic [QUOT_W-1:0]     div_q;
    logic                  mode_draws;
    logic                  cfg_wr;

    fhh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    // Configuration write and read back
    always_comb begin
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        colour_mode_next = colour_mode_reg;
        prdata           = '0;
        if (cfg_wr) begin
            case (paddr[3:2])
                REG_GRID_WIDTH:  grid_width_next  = pwdata[GRID_W-1:0];
                REG_GRID_HEIGHT: grid_height_next = pwdata[GRID_W-1:0];
                REG_COLOUR_MODE: colour_mode_next = pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
        case (paddr[3:2])
            REG_GRID_WIDTH:  prdata = PDATA_W'(grid_width_reg);
            REG_GRID_HEIGHT: prdata = PDATA_W'(grid_height_reg);
            REG_COLOUR_MODE: prdata = PDATA_W'(colour_mode_reg);
            default:         prdata = '0;
        endcase
    end

    // Slot reduction: reciprocal estimate, then one correction step
    assign q_est     = prod_reg[PROD_W-1:RECIP_K];
    assign q_mul     = q_est * FRAME_W'(FRAME_SLOTS);
    assign frame_rem = item_reg.frame - q_mul;
    assign frame_fix = (frame_rem >= FRAME_W'(FRAME_SLOTS)) ?
                       frame_rem - FRAME_W'(FRAME_SLOTS) : frame_rem;

    // Saturating add
    assign add_amt = (item_reg.action == ACT_ADD_POINT) ? SUM_W'(1) : SUM_W'(item_reg.weight);
    assign sum     = SUM_W'(ram_rdata) + add_amt;
    assign sat     = (sum[SUM_W-1:COUNT_BITS] != '0) ? '1 : sum[COUNT_BITS-1:0];

    // Divider step
    assign div_ge = (rem_reg >= dsr_reg);
    assign div_q  = {q_reg[QUOT_W-2:0], div_ge};

    assign mode_draws = (colour_mode_reg == MODE_RED) || (colour_mode_reg == MODE_GRAY);

    // Next state and datapath
    always_comb begin
        state_next    = state_reg;
        item_next     = item_reg;
        prod_next     = prod_reg;
        slot_next     = slot_reg;
        prev_next     = prev_reg;
        in_grid_next  = in_grid_reg;
        off_next      = off_reg;
        addr_next     = addr_reg;
        src_base_next = src_base_reg;
        dst_base_next = dst_base_reg;
        idx_next      = idx_reg;
        widx_next     = widx_reg;
        act_next      = act_reg;
        clr_next      = clr_reg;
        peak_next     = peak_reg;
        c_next        = c_reg;
        rem_next      = rem_reg;
        dsr_next      = dsr_reg;
        q_next        = q_reg;
        step_next     = step_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_valid_next  = m_valid_reg;
        ram_we        = 1'b0;
        ram_waddr     = addr_reg;
        ram_wdata     = '0;
        ram_raddr     = addr_reg;

        // Drain the output register
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            // Zero the store, one entry a cycle
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_SLOT;
                end
            end

            // Estimate frame / FRAME_SLOTS
            ST_SLOT: begin
                prod_next  = PROD_W'(item_reg.frame) * PROD_W'(RECIP);
                state_next = ST_MOD;
            end

            // Finish the slot, check the grid, form the bin offset
            ST_MOD: begin
                slot_next    = SLOT_W'(frame_fix);
                prev_next    = (SLOT_W'(frame_fix) == '0) ? SLOT_W'(FRAME_SLOTS - 1)
                                                          : SLOT_W'(frame_fix) - 1'b1;
                in_grid_next = ({1'b0, item_reg.x} < grid_width_reg) &&
                               (32'(item_reg.x) < MAX_WIDTH) &&
                               ({1'b0, item_reg.y} < grid_height_reg) &&
                               (32'(item_reg.y) < MAX_HEIGHT);
                off_next     = BIN_W'(BIN_W'(item_reg.y) * BIN_W'(MAX_WIDTH)) +
                               BIN_W'(item_reg.x);
                state_next   = ST_ISSUE;
            end

            // Dispatch on the action and issue the bin read
            ST_ISSUE: begin
                res_next       = '0;
                res_next.peak  = RESULT_W'(peak_reg);
                addr_next      = ADDR_W'(slot_reg) * ADDR_W'(SLOT_BINS) + ADDR_W'(off_reg);
                ram_raddr      = addr_next;
                if (item_reg.action == ACT_START_FRAME) begin
                    src_base_next = ADDR_W'(prev_reg) * ADDR_W'(SLOT_BINS);
                    dst_base_next = ADDR_W'(slot_reg) * ADDR_W'(SLOT_BINS);
                    idx_next      = '0;
                    act_next      = 1'b0;
                    state_next    = ST_COPY;
                end else if (!in_grid_reg) begin
                    state_next = ST_DONE;
                end else if (item_reg.action == ACT_READ_BIN) begin
                    state_next = ST_FETCH;
                end else begin
                    state_next = ST_MODIFY;
                end
            end

            // Copy the previous slot: read one bin, write the one read before
            ST_COPY: begin
                ram_raddr = src_base_reg + ADDR_W'(idx_reg);
                ram_we    = act_reg;
                ram_waddr = dst_base_reg + ADDR_W'(widx_reg);
                ram_wdata = ram_rdata;
                widx_next = idx_reg;
                act_next  = 1'b1;
                idx_next  = idx_reg + 1'b1;
                if (idx_reg == BIN_W'(SLOT_BINS - 1)) begin
                    state_next = ST_COPY_LAST;
                end
            end

            ST_COPY_LAST: begin
                ram_we     = 1'b1;
                ram_waddr  = dst_base_reg + ADDR_W'(widx_reg);
                ram_wdata  = ram_rdata;
                act_next   = 1'b0;
                state_next = ST_DONE;
            end

            // Add and write back, raise the peak
            ST_MODIFY: begin
                ram_we    = 1'b1;
                ram_waddr = addr_reg;
                ram_wdata = sat;
                if (sat > peak_reg) begin
                    peak_next = sat;
                end
                res_next.count = RESULT_W'(sat);
                res_next.peak  = RESULT_W'(peak_next);
                state_next     = ST_DONE;
            end

            // Take the read count and decide whether it is lit
            ST_FETCH: begin
                c_next         = (ram_rdata > peak_reg) ? peak_reg : ram_rdata;
                res_next.count = RESULT_W'(ram_rdata);
                if (ram_rdata != '0 && peak_reg != '0 && mode_draws) begin
                    state_next = ST_PREP;
                end else begin
                    state_next = ST_DONE;
                end
            end

            // Scale the numerator and load the divider
            ST_PREP: begin
                if (colour_mode_reg == MODE_RED) begin
                    rem_next = NUM_W'(c_reg) * NUM_W'(RED_SPAN);
                end else begin
                    rem_next = NUM_W'(peak_reg - c_reg) * NUM_W'(GRAY_SPAN);
                end
                dsr_next   = NUM_W'({peak_reg, {(QUOT_W - 1){1'b0}}});
                q_next     = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end

            // One quotient bit a cycle
            ST_DIV: begin
                rem_next  = div_ge ? rem_reg - dsr_reg : rem_reg;
                dsr_next  = dsr_reg >> 1;
                q_next    = div_q;
                step_next = step_reg + 1'b1;
                if (step_reg == 3'd7) begin
                    res_next.lit = 1'b1;
                    if (colour_mode_reg == MODE_RED) begin
                        res_next.red   = CHAN_BASE + div_q;
                        res_next.green = CHAN_BASE;
                        res_next.blue  = CHAN_BASE;
                    end else begin
                        res_next.red   = div_q;
                        res_next.green = div_q;
                        res_next.blue  = div_q;
                    end
                    state_next = ST_DONE;
                end
            end

            // Hand the result to the output register once it is free
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next     = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            clr_reg         <= '0;
            act_reg         <= 1'b0;
            peak_reg        <= '0;
            m_valid_reg     <= 1'b0;
            grid_width_reg  <= GRID_WIDTH_RST;
            grid_height_reg <= GRID_HEIGHT_RST;
            colour_mode_reg <= MODE_RED;
        end else begin
            state_reg       <= state_next;
            clr_reg         <= clr_next;
            act_reg         <= act_next;
            peak_reg        <= peak_next;
            m_valid_reg     <= m_valid_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
            colour_mode_reg <= colour_mode_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg     <= item_next;
        prod_reg     <= prod_next;
        slot_reg     <= slot_next;
        prev_reg     <= prev_next;
        in_grid_reg  <= in_grid_next;
        off_reg      <= off_next;
        addr_reg     <= addr_next;
        src_base_reg <= src_base_next;
        dst_base_reg <= dst_base_next;
        idx_reg      <= idx_next;
        widx_reg     <= widx_next;
        c_reg        <= c_next;
        rem_reg      <= rem_next;
        dsr_reg      <= dsr_next;
        q_reg        <= q_next;
        step_reg     <= step_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

endmodule
